// ===== src/dpb_pkg.sv =====
// Shared types and constants for the depth pixel back-projection block.
// Used by dpb_cam, dpb_xform and the top level depth_pixel_backprojection.
package dpb_pkg;

  // Field widths
  localparam int PIX_W   = 16;  // Q12.4 pixel coordinate
  localparam int DEPTH_W = 16;  // depth in millimetres
  localparam int INV_W   = 32;  // Q0.32 inverse focal length
  localparam int COEF_W  = 16;  // Q2.14 rotation coefficient
  localparam int OUT_W   = 21;  // output point component
  localparam int CFG_W   = 64;  // widest configuration register
  localparam int CFG_IDX_W = 3;

  // Internal widths
  localparam int MAG_W  = PIX_W;              // |pixel - centre|
  localparam int MD_W   = MAG_W + DEPTH_W;    // |d| * depth
  localparam int PRD_W  = MD_W + INV_W;       // |d| * depth * inv, 36 fraction bits
  localparam int CAM_W  = 37;                 // signed camera x/y, Q8
  localparam int ZC_W   = DEPTH_W + 8;        // camera z, Q8
  localparam int MUL_W  = COEF_W + CAM_W;     // coefficient product, Q22
  localparam int SUM_W  = MUL_W + 3;          // row sum with translation
  localparam int QUO_W  = SUM_W - 22;         // rounded integer result

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_INVERSE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_POINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_ROW_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_ROW_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_ROW_Z  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATION     = 3'd5;

  // Reset values: identity rotation
  localparam logic [47:0] ROW_X_RST = 48'h4000_0000_0000;
  localparam logic [47:0] ROW_Y_RST = 48'h0000_4000_0000;
  localparam logic [47:0] ROW_Z_RST = 48'h0000_0000_4000;

  // Saturation limits
  localparam logic signed [QUO_W-1:0] OUT_MAX = QUO_W'(1048575);
  localparam logic signed [QUO_W-1:0] OUT_MIN = -QUO_W'(1048576);

  // Camera-space point handed from back-projection to transform
  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic signed [CAM_W-1:0] xc;
    logic signed [CAM_W-1:0] yc;
    logic [ZC_W-1:0]         zc;
  } cam_pt_t;

endpackage

// ===== src/depth_pixel_backprojection.sv =====
// Top level of the depth pixel back-projection block: configuration registers
// and the two pipelines. Depends on dpb_pkg, dpb_cam and dpb_xform.
//
// Usage:
//   A request (in_pixel_u, in_pixel_v, in_depth_mm) is taken at a rising edge
//   with start high and busy low. busy is always low: the pipeline takes one
//   request per clock, every clock.
//   Each request yields one point on out_point_x/y/z and out_zero_depth,
//   marked by out_valid for exactly one cycle. There are 7 register stages
//   (4 of back-projection, 3 of transform).
//   Requests leave in the order they came.
//   The receiver cannot stall; results are shown once and then dropped.
//   Configuration: cfg_we high writes cfg_wdata into register cfg_index at
//   the clock edge; indexes beyond translation are ignored. Write only while
//   no request is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline and loads zero focal
//   inverses, principal point and translation and the identity rotation.
module depth_pixel_backprojection (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [dpb_pkg::PIX_W-1:0]           in_pixel_u,
  input  logic [dpb_pkg::PIX_W-1:0]           in_pixel_v,
  input  logic [dpb_pkg::DEPTH_W-1:0]         in_depth_mm,
  output logic                                out_valid,
  output logic signed [dpb_pkg::OUT_W-1:0]    out_point_x,
  output logic signed [dpb_pkg::OUT_W-1:0]    out_point_y,
  output logic signed [dpb_pkg::OUT_W-1:0]    out_point_z,
  output logic                                out_zero_depth,
  input  logic                                cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpb_pkg::CFG_W-1:0]           cfg_wdata
);

  // Configuration registers
  logic [63:0]                             focal_inverse_r;
  logic [31:0]                             principal_point_r;
  logic [2:0][3*dpb_pkg::COEF_W-1:0]       rows_r;
  logic [3*dpb_pkg::OUT_W-1:0]             translation_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_inverse_r   <= '0;
      principal_point_r <= '0;
      rows_r[0]         <= dpb_pkg::ROW_X_RST;
      rows_r[1]         <= dpb_pkg::ROW_Y_RST;
      rows_r[2]         <= dpb_pkg::ROW_Z_RST;
      translation_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dpb_pkg::CFG_FOCAL_INVERSE:   focal_inverse_r   <= cfg_wdata;
        dpb_pkg::CFG_PRINCIPAL_POINT: principal_point_r <= cfg_wdata[31:0];
        dpb_pkg::CFG_ROTATION_ROW_X:  rows_r[0]         <= cfg_wdata[47:0];
        dpb_pkg::CFG_ROTATION_ROW_Y:  rows_r[1]         <= cfg_wdata[47:0];
        dpb_pkg::CFG_ROTATION_ROW_Z:  rows_r[2]         <= cfg_wdata[47:0];
        dpb_pkg::CFG_TRANSLATION:     translation_r     <= cfg_wdata[62:0];
        default: ;
      endcase
    end
  end

  // Pipeline always accepts
  assign busy = 1'b0;

  dpb_pkg::cam_pt_t cam_pt;

  dpb_cam u_cam (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .pixel_u  (in_pixel_u),
    .pixel_v  (in_pixel_v),
    .depth_mm (in_depth_mm),
    .cx       (principal_point_r[31:16]),
    .cy       (principal_point_r[15:0]),
    .inv_fx   (focal_inverse_r[63:32]),
    .inv_fy   (focal_inverse_r[31:0]),
    .pt       (cam_pt)
  );

  dpb_xform u_xform (
    .clk         (clk),
    .rst_n       (rst_n),
    .pt          (cam_pt),
    .rows        (rows_r),
    .translation (translation_r),
    .out_valid   (out_valid),
    .point_x     (out_point_x),
    .point_y     (out_point_y),
    .point_z     (out_point_z),
    .zero_depth  (out_zero_depth)
  );

endmodule

// ===== src/dpb_cam.sv =====
// Back-projection pipeline: pixel and depth to camera-space point (Q8).
// Four register stages; depends on dpb_pkg.
module dpb_cam (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [dpb_pkg::PIX_W-1:0]     pixel_u,
  input  logic [dpb_pkg::PIX_W-1:0]     pixel_v,
  input  logic [dpb_pkg::DEPTH_W-1:0]   depth_mm,
  input  logic [dpb_pkg::PIX_W-1:0]     cx,
  input  logic [dpb_pkg::PIX_W-1:0]     cy,
  input  logic [dpb_pkg::INV_W-1:0]     inv_fx,
  input  logic [dpb_pkg::INV_W-1:0]     inv_fy,
  output dpb_pkg::cam_pt_t              pt
);

  // Stage 1: offset from principal point as sign and magnitude
  logic [dpb_pkg::PIX_W:0]       dx_nxt, dy_nxt, ndx_nxt, ndy_nxt;
  logic                          s1_valid_r;
  logic                          s1_sx_r, s1_sy_r;
  logic [dpb_pkg::MAG_W-1:0]     s1_mx_r, s1_my_r;
  logic [dpb_pkg::DEPTH_W-1:0]   s1_depth_r;

  assign dx_nxt  = {1'b0, pixel_u} - {1'b0, cx};
  assign dy_nxt  = {1'b0, pixel_v} - {1'b0, cy};
  assign ndx_nxt = -dx_nxt;
  assign ndy_nxt = -dy_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_sx_r    <= dx_nxt[dpb_pkg::PIX_W];
    s1_sy_r    <= dy_nxt[dpb_pkg::PIX_W];
    s1_mx_r    <= dx_nxt[dpb_pkg::PIX_W] ? ndx_nxt[dpb_pkg::MAG_W-1:0]
                                         : dx_nxt[dpb_pkg::MAG_W-1:0];
    s1_my_r    <= dy_nxt[dpb_pkg::PIX_W] ? ndy_nxt[dpb_pkg::MAG_W-1:0]
                                         : dy_nxt[dpb_pkg::MAG_W-1:0];
    s1_depth_r <= depth_mm;
  end

  // Stage 2: scale magnitude by depth
  logic                          s2_valid_r;
  logic                          s2_sx_r, s2_sy_r;
  logic [dpb_pkg::MD_W-1:0]      s2_mdx_r, s2_mdy_r;
  logic [dpb_pkg::DEPTH_W-1:0]   s2_depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_sx_r    <= s1_sx_r;
    s2_sy_r    <= s1_sy_r;
    s2_mdx_r   <= s1_mx_r * s1_depth_r;
    s2_mdy_r   <= s1_my_r * s1_depth_r;
    s2_depth_r <= s1_depth_r;
  end

  // Stage 3: multiply by inverse focal length
  logic                          s3_valid_r;
  logic                          s3_sx_r, s3_sy_r;
  logic [dpb_pkg::PRD_W-1:0]     s3_px_r, s3_py_r;
  logic [dpb_pkg::DEPTH_W-1:0]   s3_depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_sx_r    <= s2_sx_r;
    s3_sy_r    <= s2_sy_r;
    s3_px_r    <= s2_mdx_r * inv_fx;
    s3_py_r    <= s2_mdy_r * inv_fy;
    s3_depth_r <= s2_depth_r;
  end

  // Stage 4: round half away from zero to Q8 and restore sign
  logic [dpb_pkg::PRD_W:0]        rx_sum_nxt, ry_sum_nxt;
  logic [dpb_pkg::CAM_W-1:0]      rx_nxt, ry_nxt;
  dpb_pkg::cam_pt_t               pt_r;

  assign rx_sum_nxt = {1'b0, s3_px_r} + (dpb_pkg::PRD_W+1)'(1 << 27);
  assign ry_sum_nxt = {1'b0, s3_py_r} + (dpb_pkg::PRD_W+1)'(1 << 27);
  assign rx_nxt     = {1'b0, rx_sum_nxt[dpb_pkg::PRD_W-1 -: dpb_pkg::CAM_W-1]};
  assign ry_nxt     = {1'b0, ry_sum_nxt[dpb_pkg::PRD_W-1 -: dpb_pkg::CAM_W-1]};

  // Reset only the valid bit; advance the point fields every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r.valid <= 1'b0;
    end else begin
      pt_r.valid <= s3_valid_r;
    end
    pt_r.zero <= (s3_depth_r == '0);
    pt_r.xc   <= s3_sx_r ? -$signed(rx_nxt) : $signed(rx_nxt);
    pt_r.yc   <= s3_sy_r ? -$signed(ry_nxt) : $signed(ry_nxt);
    pt_r.zc   <= {s3_depth_r, 8'h00};
  end

  assign pt = pt_r;

endmodule

// ===== src/dpb_xform.sv =====
// Rigid transform pipeline: rotation, translation, rounding and saturation.
// Three register stages; depends on dpb_pkg.
module dpb_xform (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dpb_pkg::cam_pt_t                     pt,
  input  logic [2:0][3*dpb_pkg::COEF_W-1:0]    rows,
  input  logic [3*dpb_pkg::OUT_W-1:0]          translation,
  output logic                                 out_valid,
  output logic signed [dpb_pkg::OUT_W-1:0]     point_x,
  output logic signed [dpb_pkg::OUT_W-1:0]     point_y,
  output logic signed [dpb_pkg::OUT_W-1:0]     point_z,
  output logic                                 zero_depth
);

  // Stage 5: nine coefficient products
  logic                                    s5_valid_r;
  logic                                    s5_zero_r;
  logic signed [dpb_pkg::MUL_W-1:0]        s5_prod_r [3][3];
  logic signed [dpb_pkg::ZC_W:0]           zc_s;

  assign zc_s = $signed({1'b0, pt.zc});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_zero_r <= pt.zero;
    for (int r = 0; r < 3; r++) begin
      s5_prod_r[r][0] <= $signed(rows[r][3*dpb_pkg::COEF_W-1 -: dpb_pkg::COEF_W]) * pt.xc;
      s5_prod_r[r][1] <= $signed(rows[r][2*dpb_pkg::COEF_W-1 -: dpb_pkg::COEF_W]) * pt.yc;
      s5_prod_r[r][2] <= $signed(rows[r][dpb_pkg::COEF_W-1:0]) * zc_s;
    end
  end

  // Stage 6: sum row products with translation at Q22
  logic                                    s6_valid_r;
  logic                                    s6_zero_r;
  logic signed [dpb_pkg::SUM_W-1:0]        s6_sum_r [3];
  logic signed [dpb_pkg::SUM_W-1:0]        sum_nxt [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = dpb_pkg::SUM_W'(s5_prod_r[r][0])
                 + dpb_pkg::SUM_W'(s5_prod_r[r][1])
                 + dpb_pkg::SUM_W'(s5_prod_r[r][2])
                 + (dpb_pkg::SUM_W'($signed(
                     translation[(2-r)*dpb_pkg::OUT_W +: dpb_pkg::OUT_W])) <<< 22);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_zero_r <= s5_zero_r;
    for (int r = 0; r < 3; r++) begin
      s6_sum_r[r] <= sum_nxt[r];
    end
  end

  // Stage 7: round half up to integer, then saturate
  logic                                    out_valid_r;
  logic                                    zero_r;
  logic signed [dpb_pkg::OUT_W-1:0]        pnt_r [3];
  logic signed [dpb_pkg::SUM_W-1:0]        rnd_nxt [3];
  logic signed [dpb_pkg::QUO_W-1:0]        quo_nxt [3];
  logic signed [dpb_pkg::OUT_W-1:0]        sat_nxt [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rnd_nxt[r] = s6_sum_r[r] + dpb_pkg::SUM_W'(1 << 21);
      quo_nxt[r] = rnd_nxt[r][dpb_pkg::SUM_W-1:22];
      if (quo_nxt[r] > dpb_pkg::OUT_MAX) begin
        sat_nxt[r] = dpb_pkg::OUT_MAX[dpb_pkg::OUT_W-1:0];
      end else if (quo_nxt[r] < dpb_pkg::OUT_MIN) begin
        sat_nxt[r] = dpb_pkg::OUT_MIN[dpb_pkg::OUT_W-1:0];
      end else begin
        sat_nxt[r] = quo_nxt[r][dpb_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= s6_zero_r;
    for (int r = 0; r < 3; r++) begin
      pnt_r[r] <= sat_nxt[r];
    end
  end

  assign out_valid  = out_valid_r;
  assign point_x    = pnt_r[0];
  assign point_y    = pnt_r[1];
  assign point_z    = pnt_r[2];
  assign zero_depth = zero_r;

endmodule

// ===== tb/dpb_point_checker.sv =====
// Checker for the depth pixel back-projection block: tracks register writes,
// predicts each transformed point and compares it with what the block shows.
// Depends on dpb_pkg for widths, register indexes and saturation limits.
module dpb_point_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic [dpb_pkg::PIX_W-1:0]        in_pixel_u,
  input  logic [dpb_pkg::PIX_W-1:0]        in_pixel_v,
  input  logic [dpb_pkg::DEPTH_W-1:0]      in_depth_mm,
  input  logic                             out_valid,
  input  logic signed [dpb_pkg::OUT_W-1:0] out_point_x,
  input  logic signed [dpb_pkg::OUT_W-1:0] out_point_y,
  input  logic signed [dpb_pkg::OUT_W-1:0] out_point_z,
  input  logic                             out_zero_depth,
  input  logic                             cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpb_pkg::CFG_W-1:0]        cfg_wdata,
  output int                               mismatch_count,
  output int                               points_pending
);
  import dpb_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    zero;
  } point_t;

  // Local copy of the camera and pose registers
  logic [63:0] inv_focal;
  logic [31:0] centre;
  logic [47:0] row_x, row_y, row_z;
  logic [62:0] offset;

  point_t expected_points[$];

  initial begin
    mismatch_count = 0;
    points_pending = 0;
  end

  // Scale the pixel offset from the principal point by depth / focal length, Q8
  function automatic longint camera_offset(logic [15:0] pix, logic [15:0] centre_q4,
                                           logic [15:0] depth, logic [31:0] inv);
    longint      diff;
    logic [63:0] mag;
    diff = longint'(pix) - longint'(centre_q4);
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    mag  = mag * 64'(depth) * 64'(inv);
    // round half away from zero from 36 to 8 fraction bits
    mag  = (mag + (64'd1 << 27)) >> 28;
    return (diff < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // One output axis: rotation row dot camera point plus offset, rounded and clamped
  function automatic logic [OUT_W-1:0] rotate_row(logic [47:0] row, longint xc, longint yc,
                                                  longint zc, logic [20:0] shift_mm);
    longint acc;
    acc = longint'($signed(row[47:32])) * xc
        + longint'($signed(row[31:16])) * yc
        + longint'($signed(row[15:0])) * zc
        + (longint'($signed(shift_mm)) <<< 22);
    // halves go toward plus infinity
    acc = (acc + (longint'(1) <<< 21)) >>> 22;
    if (acc < longint'(OUT_MIN)) begin
      acc = longint'(OUT_MIN);
    end else if (acc > longint'(OUT_MAX)) begin
      acc = longint'(OUT_MAX);
    end
    return acc[OUT_W-1:0];
  endfunction

  function automatic point_t backproject_point(logic [15:0] u, logic [15:0] v,
                                               logic [15:0] depth);
    longint xc, yc, zc;
    point_t p;
    xc     = camera_offset(u, centre[31:16], depth, inv_focal[63:32]);
    yc     = camera_offset(v, centre[15:0], depth, inv_focal[31:0]);
    zc     = longint'(depth) <<< 8;
    p.x    = rotate_row(row_x, xc, yc, zc, offset[62:42]);
    p.y    = rotate_row(row_y, xc, yc, zc, offset[41:21]);
    p.z    = rotate_row(row_z, xc, yc, zc, offset[20:0]);
    p.zero = (depth == 0);
    return p;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("point check: %s got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Compare results first, then queue new requests, then follow register writes
  always @(posedge clk) begin : watch
    point_t want;
    if (!rst_n) begin
      inv_focal = '0;
      centre    = '0;
      row_x     = ROW_X_RST;
      row_y     = ROW_Y_RST;
      row_z     = ROW_Z_RST;
      offset    = '0;
      expected_points.delete();
    end else begin
      if (out_valid) begin
        if (expected_points.size() == 0) begin
          report_mismatch("point with no request waiting, x", longint'(out_point_x), 0);
        end else begin
          want = expected_points.pop_front();
          if (out_point_x !== want.x)
            report_mismatch("point_x", longint'(out_point_x), longint'(want.x));
          if (out_point_y !== want.y)
            report_mismatch("point_y", longint'(out_point_y), longint'(want.y));
          if (out_point_z !== want.z)
            report_mismatch("point_z", longint'(out_point_z), longint'(want.z));
          if (out_zero_depth !== want.zero)
            report_mismatch("zero_depth", longint'(out_zero_depth), longint'(want.zero));
        end
      end
      if (start && !busy) begin
        expected_points.insert(expected_points.size(),
                               backproject_point(in_pixel_u, in_pixel_v, in_depth_mm));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FOCAL_INVERSE:   inv_focal = cfg_wdata;
          CFG_PRINCIPAL_POINT: centre    = cfg_wdata[31:0];
          CFG_ROTATION_ROW_X:  row_x     = cfg_wdata[47:0];
          CFG_ROTATION_ROW_Y:  row_y     = cfg_wdata[47:0];
          CFG_ROTATION_ROW_Z:  row_z     = cfg_wdata[47:0];
          CFG_TRANSLATION:     offset    = cfg_wdata[62:0];
          default: ;
        endcase
      end
    end
    points_pending = expected_points.size();
  end

endmodule

// ===== tb/depth_pixel_backprojection_test.sv =====
// Testbench top for depth_pixel_backprojection: drives pixel requests and
// register writes, runs a cycle watchdog and gives the verdict.
// Depends on dpb_pkg, the block itself and dpb_point_checker.
module depth_pixel_backprojection_test;
  import dpb_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASES         = 8;
  localparam int PHASE_PIXELS   = 130;
  localparam int TAIL_PIXELS    = 100;

  // Indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [PIX_W-1:0]        in_pixel_u, in_pixel_v;
  logic [DEPTH_W-1:0]      in_depth_mm;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_point_x, out_point_y, out_point_z;
  logic                    out_zero_depth;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;
  int                      mismatch_count;
  int                      points_pending;
  int                      stall_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  depth_pixel_backprojection uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_pixel_u     (in_pixel_u),
    .in_pixel_v     (in_pixel_v),
    .in_depth_mm    (in_depth_mm),
    .out_valid      (out_valid),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_z    (out_point_z),
    .out_zero_depth (out_zero_depth),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  dpb_point_checker point_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_pixel_u     (in_pixel_u),
    .in_pixel_v     (in_pixel_v),
    .in_depth_mm    (in_depth_mm),
    .out_valid      (out_valid),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_z    (out_point_z),
    .out_zero_depth (out_zero_depth),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .points_pending (points_pending)
  );

  // Watchdog: end the run after too many cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pack_row(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    return {16'h0000, a, b, c};
  endfunction

  function automatic logic [63:0] pack_offset(logic [20:0] tx, logic [20:0] ty,
                                              logic [20:0] tz);
    // top bit lies outside the register and must be dropped
    return {1'($urandom), tx, ty, tz};
  endfunction

  function automatic logic [15:0] pick_coefficient();
    case ($urandom_range(0, 3))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'h4000;
    endcase
  endfunction

  function automatic logic [20:0] pick_offset();
    case ($urandom_range(0, 2))
      0:       return 21'h0F_FFFF;
      1:       return 21'h10_0000;
      default: return 21'h00_0000;
    endcase
  endfunction

  function automatic logic [15:0] random_coefficient();
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [31:0] random_inverse();
    return 32'((64'd1 << 32) / 64'($urandom_range(200, 1500)));
  endfunction

  // Write one register: hold enable for one edge, then drop it
  task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Present one request and hold it until taken
  task automatic issue_pixel(input logic [15:0] u, input logic [15:0] v,
                             input logic [15:0] depth);
    start       <= 1'b1;
    in_pixel_u  <= u;
    in_pixel_v  <= v;
    in_depth_mm <= depth;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start for a short burst with noise on the fields
  task automatic idle_burst();
    start       <= 1'b0;
    in_pixel_u  <= 16'($urandom);
    in_pixel_v  <= 16'($urandom);
    in_depth_mm <= 16'($urandom);
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // Stop sending and wait until every expected point has come back
  task automatic drain_points();
    start <= 1'b0;
    while (points_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_pixel(output logic [15:0] u, output logic [15:0] v,
                              output logic [15:0] depth);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // plausible sensor pixel
      u     = 16'($urandom_range(0, 1280 * 16 - 1));
      v     = 16'($urandom_range(0, 960 * 16 - 1));
      depth = 16'($urandom_range(200, 10000));
    end else if (pick < 80) begin
      u     = 16'($urandom);
      v     = 16'($urandom);
      depth = '0;
    end else if (pick < 92) begin
      u     = 16'($urandom);
      v     = 16'($urandom);
      depth = 16'($urandom);
    end else begin
      u     = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      v     = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      depth = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 2));
    end
  endtask

  // Pick a new camera and pose setting; only call while drained
  task automatic configure_random();
    int mode;
    mode = $urandom_range(0, 3);
    case (mode)
      0: begin
        load_register(CFG_FOCAL_INVERSE, {random_inverse(), random_inverse()});
        load_register(CFG_PRINCIPAL_POINT,
                      64'({16'($urandom_range(1600, 16000)),
                           16'($urandom_range(1600, 12000))}));
        load_register(CFG_ROTATION_ROW_X, pack_row(random_coefficient(), random_coefficient(),
                                                   random_coefficient()));
        load_register(CFG_ROTATION_ROW_Y, pack_row(random_coefficient(), random_coefficient(),
                                                   random_coefficient()));
        load_register(CFG_ROTATION_ROW_Z, pack_row(random_coefficient(), random_coefficient(),
                                                   random_coefficient()));
        load_register(CFG_TRANSLATION,
                      pack_offset(21'(int'($urandom_range(0, 8000)) - 4000),
                                  21'(int'($urandom_range(0, 8000)) - 4000),
                                  21'(int'($urandom_range(0, 8000)) - 4000)));
      end
      1: begin
        // full-width junk exercises the masking of narrow registers
        load_register(CFG_FOCAL_INVERSE, rand64());
        load_register(CFG_PRINCIPAL_POINT, rand64());
        load_register(CFG_ROTATION_ROW_X, rand64());
        load_register(CFG_ROTATION_ROW_Y, rand64());
        load_register(CFG_ROTATION_ROW_Z, rand64());
        load_register(CFG_TRANSLATION, rand64());
      end
      2: begin
        load_register(CFG_FOCAL_INVERSE, {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0,
                                          $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0});
        load_register(CFG_PRINCIPAL_POINT, $urandom_range(0, 1) ? 64'hFFFF_FFFF : 64'h0);
        load_register(CFG_ROTATION_ROW_X, pack_row(pick_coefficient(), pick_coefficient(),
                                                   pick_coefficient()));
        load_register(CFG_ROTATION_ROW_Y, pack_row(pick_coefficient(), pick_coefficient(),
                                                   pick_coefficient()));
        load_register(CFG_ROTATION_ROW_Z, pack_row(pick_coefficient(), pick_coefficient(),
                                                   pick_coefficient()));
        load_register(CFG_TRANSLATION, pack_offset(pick_offset(), pick_offset(),
                                                   pick_offset()));
      end
      default: begin
        // partial update plus writes that must fall on nothing
        load_register(CFG_FOCAL_INVERSE, {random_inverse(), random_inverse()});
        load_register(CFG_SPARE_A, rand64());
        load_register(CFG_TRANSLATION, pack_offset(21'($urandom), 21'($urandom),
                                                   21'($urandom)));
        load_register(CFG_SPARE_B, rand64());
      end
    endcase
  endtask

  task automatic run_pixels(input int count, input bit idle_on);
    logic [15:0] u, v, depth;
    for (int i = 0; i < count; i++) begin
      random_pixel(u, v, depth);
      issue_pixel(u, v, depth);
      if (idle_on && $urandom_range(0, 7) == 0) idle_burst();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_pixel_u  = '0;
    in_pixel_v  = '0;
    in_depth_mm = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting: identity pose, zero focal inverses
    issue_pixel(16'h0000, 16'h0000, 16'h0000);
    issue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue_pixel(16'd1234, 16'd567, 16'd1);

    // Typical camera, quarter turn about z, small offset
    drain_points();
    load_register(CFG_FOCAL_INVERSE, {random_inverse(), 32'd8180962});
    load_register(CFG_PRINCIPAL_POINT, 64'({16'd5120, 16'd3840}));
    load_register(CFG_ROTATION_ROW_X, pack_row(16'h0000, 16'hC000, 16'h0000));
    load_register(CFG_ROTATION_ROW_Y, pack_row(16'h4000, 16'h0000, 16'h0000));
    load_register(CFG_ROTATION_ROW_Z, 64'(ROW_Z_RST));
    load_register(CFG_TRANSLATION, pack_offset(21'd100, -21'd200, 21'd300));
    issue_pixel(16'd5120, 16'd3840, 16'd1000);
    issue_pixel(16'd0, 16'd0, 16'd4000);
    issue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue_pixel(16'd5136, 16'd3840, 16'd0);
    issue_pixel(16'd100, 16'd9000, 16'd1);

    // Largest gains and extreme offsets: the first pixel drives every axis into positive saturation
    drain_points();
    load_register(CFG_FOCAL_INVERSE, 64'hFFFF_FFFF_FFFF_FFFF);
    load_register(CFG_PRINCIPAL_POINT, 64'h0);
    load_register(CFG_ROTATION_ROW_X, pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF));
    load_register(CFG_ROTATION_ROW_Y, pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF));
    load_register(CFG_ROTATION_ROW_Z, pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF));
    load_register(CFG_TRANSLATION, pack_offset(21'h0F_FFFF, 21'h10_0000, 21'h0));
    issue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue_pixel(16'h0000, 16'h0000, 16'h0000);
    issue_pixel(16'hFFFF, 16'h0000, 16'd1);

    // Most negative and most positive coefficients, centre at the far corner: saturation both ways
    drain_points();
    load_register(CFG_PRINCIPAL_POINT, 64'hFFFF_FFFF);
    load_register(CFG_ROTATION_ROW_X, pack_row(16'h8000, 16'h8000, 16'h8000));
    load_register(CFG_ROTATION_ROW_Y, pack_row(16'h7FFF, 16'h7FFF, 16'h8000));
    load_register(CFG_ROTATION_ROW_Z, pack_row(16'h8000, 16'h0000, 16'h7FFF));
    load_register(CFG_TRANSLATION, pack_offset(21'h10_0000, 21'h0F_FFFF, 21'h10_0000));
    issue_pixel(16'h0000, 16'h0000, 16'hFFFF);
    issue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue_pixel(16'h0000, 16'hFFFF, 16'h0000);

    // Random settings, each followed by a random pixel stream
    for (int p = 0; p < PHASES; p++) begin
      drain_points();
      configure_random();
      run_pixels(PHASE_PIXELS, $urandom_range(0, 3) != 0);
    end

    // Closing stretch back to back, no gaps
    drain_points();
    configure_random();
    run_pixels(TAIL_PIXELS, 1'b0);

    start <= 1'b0;
    while (points_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && points_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dpb_pkg.sv
src/dpb_cam.sv
src/dpb_xform.sv
src/depth_pixel_backprojection.sv
tb/dpb_point_checker.sv
tb/depth_pixel_backprojection_test.sv
